[src/mlht_pkg.sv]
// Shared definitions for the MAC learning hash table: field widths, default
// table geometry, result status codes and the result word layout.
// No dependencies.
`default_nettype none

package mlht_pkg;

	localparam int MAC_W        = 48;
	localparam int BUCKET_OUT_W = 14;
	localparam int WAY_OUT_W    = 2;
	localparam int STATUS_W     = 2;

	localparam int BUCKETS_DEF  = 16384;
	localparam int WAYS_DEF     = 4;

	localparam int RES_W        = BUCKET_OUT_W + WAY_OUT_W + STATUS_W;
	localparam int OUT_TDATA_W  = ((RES_W + 7) / 8) * 8;

	typedef enum logic [STATUS_W-1:0] {
		ST_PRESENT = 2'd0,
		ST_LEARNED = 2'd1,
		ST_DROPPED = 2'd2
	} status_t;

	// Bucket sits in the lowest bits, status in the highest.
	typedef struct packed {
		status_t                 status;
		logic [WAY_OUT_W-1:0]    way;
		logic [BUCKET_OUT_W-1:0] bucket;
	} result_t;

endpackage

`default_nettype wire

[src/mlht_ram.sv]
// Generic single-write, single-read synchronous RAM with a registered read.
// No dependencies.
`default_nettype none

module mlht_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

[src/mlht_hash.sv]
// Byte-serial one-at-a-time hash of a 48-bit address, reduced to a bucket
// index by a mask or a reciprocal multiply. Depends on mlht_pkg.
`default_nettype none

module mlht_hash #(
	parameter int BUCKETS = mlht_pkg::BUCKETS_DEF,
	localparam int BUCKET_W = $clog2(BUCKETS)
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      in_valid,
	output logic                           in_ready,
	input  wire logic [mlht_pkg::MAC_W-1:0] in_mac,
	output logic                           out_valid,
	input  wire logic                      out_ready,
	output logic      [mlht_pkg::MAC_W-1:0] out_mac,
	output logic      [BUCKET_W-1:0]       out_bucket
);

	import mlht_pkg::*;

	localparam bit BUCKET_POW2 = (BUCKETS & (BUCKETS - 1)) == 0;
	// The quotient taken with this reciprocal is exact or one too small.
	localparam logic [31:0]       RECIP   = 32'((64'd1 << 32) / BUCKETS);
	localparam logic [BUCKET_W:0] BKT_NUM = (BUCKET_W + 1)'(BUCKETS);

	typedef enum logic [2:0] {
		H_IDLE,
		H_BYTE,
		H_MIXA,
		H_MIXB,
		H_QUOT,
		H_PROD,
		H_REM,
		H_DONE
	} hstate_t;

	function automatic logic [31:0] oat_byte(input logic [31:0] h, input logic [7:0] b);
		logic [31:0] t;
		t = h + {24'd0, b};
		t = t + (t << 10);
		return t ^ (t >> 6);
	endfunction

	function automatic logic [31:0] oat_mix_a(input logic [31:0] h);
		logic [31:0] t;
		t = h + (h << 3);
		return t ^ (t >> 11);
	endfunction

	function automatic logic [31:0] oat_mix_b(input logic [31:0] h);
		return h + (h << 15);
	endfunction

	hstate_t             state_q;
	logic [2:0]          byte_cnt_q;
	logic [31:0]         hash_q;
	logic [MAC_W-1:0]    mac_q;
	logic [BUCKET_W-1:0] bucket_q;
	logic [BUCKET_W:0]   quot_q;
	logic [BUCKET_W:0]   qb_q;
	logic [7:0]          cur_byte;
	logic [31:0]         mix_b;
	logic [63:0]         recip_prod;
	logic [BUCKET_W:0]   rem_raw;
	logic [BUCKET_W:0]   rem_fix;
	logic                accept;

	assign in_ready   = (state_q == H_IDLE) || ((state_q == H_DONE) && out_ready);
	assign accept     = in_valid && in_ready;
	assign out_valid  = (state_q == H_DONE);
	assign out_mac    = mac_q;
	assign out_bucket = bucket_q;

	always_comb begin
		// Most significant byte goes first.
		cur_byte   = mac_q[{3'd5 - byte_cnt_q, 3'b000} +: 8];
		mix_b      = oat_mix_b(hash_q);
		recip_prod = {32'd0, hash_q} * {32'd0, RECIP};
		// The remainder is below twice the bucket count, so the low bits suffice.
		rem_raw    = hash_q[BUCKET_W:0] - qb_q;
		if (rem_raw >= BKT_NUM) begin
			rem_fix = rem_raw - BKT_NUM;
		end else begin
			rem_fix = rem_raw;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= H_IDLE;
		end else begin
			case (state_q)
				H_IDLE: begin
					if (accept) begin
						state_q <= H_BYTE;
					end
				end
				H_BYTE: begin
					hash_q <= oat_byte(hash_q, cur_byte);
					if (byte_cnt_q == 3'd5) begin
						state_q <= H_MIXA;
					end else begin
						byte_cnt_q <= byte_cnt_q + 3'd1;
					end
				end
				H_MIXA: begin
					hash_q  <= oat_mix_a(hash_q);
					state_q <= H_MIXB;
				end
				H_MIXB: begin
					hash_q <= mix_b;
					if (BUCKET_POW2) begin
						bucket_q <= mix_b[BUCKET_W-1:0];
						state_q  <= H_DONE;
					end else begin
						state_q <= H_QUOT;
					end
				end
				H_QUOT: begin
					quot_q  <= recip_prod[32 +: BUCKET_W + 1];
					state_q <= H_PROD;
				end
				H_PROD: begin
					qb_q    <= quot_q * BKT_NUM;
					state_q <= H_REM;
				end
				H_REM: begin
					bucket_q <= rem_fix[BUCKET_W-1:0];
					state_q  <= H_DONE;
				end
				H_DONE: begin
					if (out_ready) begin
						state_q <= accept ? H_BYTE : H_IDLE;
					end
				end
				default: begin
					state_q <= H_IDLE;
				end
			endcase
			if (accept) begin
				mac_q      <= in_mac;
				hash_q     <= '0;
				byte_cnt_q <= '0;
			end
		end
	end

endmodule

`default_nettype wire

[src/mlht_engine.sv]
// Lookup and learn engine: reads a bucket's fill count, walks its stored keys
// and writes back new entries. Depends on mlht_pkg and mlht_ram.
`default_nettype none

module mlht_engine #(
	parameter int BUCKETS = mlht_pkg::BUCKETS_DEF,
	parameter int WAYS    = mlht_pkg::WAYS_DEF,
	localparam int BUCKET_W = $clog2(BUCKETS)
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      in_valid,
	output logic                           in_ready,
	input  wire logic [mlht_pkg::MAC_W-1:0] in_mac,
	input  wire logic [BUCKET_W-1:0]       in_bucket,
	output logic                           out_valid,
	input  wire logic                      out_ready,
	output mlht_pkg::result_t              out_res
);

	import mlht_pkg::*;

	localparam int WAY_W  = (WAYS > 1) ? $clog2(WAYS) : 1;
	localparam int FILL_W = $clog2(WAYS + 1);
	localparam int KEY_AW = (BUCKETS * WAYS > 1) ? $clog2(BUCKETS * WAYS) : 1;

	typedef enum logic [1:0] {
		S_CLEAR,
		S_IDLE,
		S_FILL,
		S_SEARCH
	} estate_t;

	estate_t             state_q;
	logic [BUCKET_W-1:0] clr_q;
	logic [MAC_W-1:0]    mac_q;
	logic [BUCKET_W-1:0] bucket_q;
	logic [FILL_W-1:0]   fill_q;
	logic [WAY_W-1:0]    way_q;
	logic                out_valid_q;
	result_t             out_res_q;

	logic [FILL_W-1:0]   fill_rdata;
	logic [FILL_W-1:0]   fill_wdata;
	logic [BUCKET_W-1:0] fill_raddr;
	logic [BUCKET_W-1:0] fill_waddr;
	logic                fill_we;
	logic [MAC_W-1:0]    key_rdata;
	logic [KEY_AW-1:0]   key_raddr;
	logic [KEY_AW-1:0]   key_waddr;
	logic                key_we;

	logic [KEY_AW-1:0]   base;
	logic [FILL_W-1:0]   fill_cur;
	logic [FILL_W-1:0]   nxt_way;
	logic [FILL_W-1:0]   key_rd_way;
	logic                last;
	logic                hit;
	logic                done;
	logic                learn;
	status_t             dec_status;
	logic [WAY_W-1:0]    dec_way;
	logic                accept;

	assign in_ready  = (state_q == S_IDLE) && (!out_valid_q || out_ready);
	assign accept    = in_valid && in_ready;
	assign out_valid = out_valid_q;
	assign out_res   = out_res_q;

	always_comb begin
		base       = KEY_AW'(bucket_q) * KEY_AW'(WAYS);
		fill_cur   = (state_q == S_FILL) ? fill_rdata : fill_q;
		nxt_way    = FILL_W'(way_q) + 1'b1;
		last       = (nxt_way == fill_q);
		hit        = (key_rdata == mac_q);
		done       = 1'b0;
		learn      = 1'b0;
		dec_status = ST_PRESENT;
		dec_way    = '0;
		case (state_q)
			S_FILL: begin
				if (fill_rdata == '0) begin
					done       = 1'b1;
					learn      = 1'b1;
					dec_status = ST_LEARNED;
				end
			end
			S_SEARCH: begin
				if (hit) begin
					done    = 1'b1;
					dec_way = way_q;
				end else if (last) begin
					done = 1'b1;
					if (fill_q < FILL_W'(WAYS)) begin
						learn      = 1'b1;
						dec_status = ST_LEARNED;
						dec_way    = fill_q[WAY_W-1:0];
					end else begin
						dec_status = ST_DROPPED;
					end
				end
			end
			default: begin
			end
		endcase
		// The read for the next way goes out while the current one is compared.
		key_rd_way = ((state_q == S_SEARCH) && !last) ? nxt_way : '0;
		key_raddr  = base + KEY_AW'(key_rd_way);
		key_waddr  = base + KEY_AW'(fill_cur);
		key_we     = learn;
		fill_raddr = (state_q == S_IDLE) ? in_bucket : bucket_q;
		fill_we    = (state_q == S_CLEAR) || learn;
		fill_waddr = (state_q == S_CLEAR) ? clr_q : bucket_q;
		fill_wdata = (state_q == S_CLEAR) ? '0 : FILL_W'(fill_cur + 1'b1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			clr_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == BUCKET_W'(BUCKETS - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (accept) begin
						mac_q    <= in_mac;
						bucket_q <= in_bucket;
						state_q  <= S_FILL;
					end
				end
				S_FILL: begin
					if (done) begin
						state_q <= S_IDLE;
					end else begin
						fill_q  <= fill_rdata;
						way_q   <= '0;
						state_q <= S_SEARCH;
					end
				end
				S_SEARCH: begin
					if (done) begin
						state_q <= S_IDLE;
					end else begin
						way_q <= nxt_way[WAY_W-1:0];
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
			if (done) begin
				out_valid_q      <= 1'b1;
				out_res_q.bucket <= BUCKET_OUT_W'(bucket_q);
				out_res_q.way    <= WAY_OUT_W'(dec_way);
				out_res_q.status <= dec_status;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	mlht_ram #(
		.WIDTH(FILL_W),
		.DEPTH(BUCKETS)
	) u_fill_ram (
		.clk  (clk),
		.we   (fill_we),
		.waddr(fill_waddr),
		.wdata(fill_wdata),
		.raddr(fill_raddr),
		.rdata(fill_rdata)
	);

	mlht_ram #(
		.WIDTH(MAC_W),
		.DEPTH(BUCKETS * WAYS)
	) u_key_ram (
		.clk  (clk),
		.we   (key_we),
		.waddr(key_waddr),
		.wdata(mac_q),
		.raddr(key_raddr),
		.rdata(key_rdata)
	);

`ifndef SYNTHESIS
	a_result_slot_free: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (!out_valid_q || out_ready))
		else $error("result produced while the output word is still held");

	a_key_write_with_fill: assert property (@(posedge clk) disable iff (!arst_n)
		key_we |-> (fill_we && (fill_wdata == FILL_W'(fill_cur + 1'b1))))
		else $error("key written without a matching fill count update");

	a_clear_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CLEAR) |-> (!key_we && !in_ready))
		else $error("key write or accept during the clearing pass");

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_we |-> (fill_wdata <= FILL_W'(WAYS)))
		else $error("fill count written beyond the number of ways");

	a_search_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SEARCH) |-> (FILL_W'(way_q) < fill_q))
		else $error("search reached a way beyond the bucket fill");
`endif

endmodule

`default_nettype wire

[src/mac_learning_hash_table.sv]
// Top level of the MAC learning hash table: hash front end and lookup engine.
// Depends on mlht_pkg, mlht_hash, mlht_engine and mlht_ram.
`default_nettype none

// Each input word carries a 48-bit MAC address. The address is hashed with
// the one-at-a-time hash, one byte per cycle and then the final mix, and the
// hash selects one of BUCKETS buckets, each of WAYS entries. A known address
// reports status 0 and its way, a new one is stored at the bucket's next free
// way with status 1, and an address that meets a full bucket is dropped with
// status 2 and way 0. Exactly one result word leaves per input word, in
// order. The hash front end takes a new address only as it hands on the last
// one, and adds reciprocal remainder steps when BUCKETS is not a power of two;
// the lookup engine, which reads the fill count and then one stored key per
// cycle from its key memory, works on the previous address meanwhile. The
// slower of the two sets the sustained rate. A result word held back by the
// receiver stops the engine and, through it, the input. After reset the fill
// counts are cleared in a pass over all BUCKETS buckets, during which no
// address reaches the engine.
module mac_learning_hash_table #(
	parameter int BUCKETS = mlht_pkg::BUCKETS_DEF,
	parameter int WAYS    = mlht_pkg::WAYS_DEF
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            s_tvalid,
	output logic                                 s_tready,
	// s_tdata: mac_address [47:0]
	input  wire logic [mlht_pkg::MAC_W-1:0]       s_tdata,
	output logic                                 m_tvalid,
	input  wire logic                            m_tready,
	// m_tdata: bucket_index [13:0], way_index [15:14], status [17:16], zero pad
	output logic      [mlht_pkg::OUT_TDATA_W-1:0] m_tdata
);

	import mlht_pkg::*;

	localparam int BUCKET_W = $clog2(BUCKETS);

	logic                hash_valid;
	logic                hash_ready;
	logic [MAC_W-1:0]    hash_mac;
	logic [BUCKET_W-1:0] hash_bucket;
	result_t             res;

	mlht_hash #(
		.BUCKETS(BUCKETS)
	) u_hash (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_mac    (s_tdata),
		.out_valid (hash_valid),
		.out_ready (hash_ready),
		.out_mac   (hash_mac),
		.out_bucket(hash_bucket)
	);

	mlht_engine #(
		.BUCKETS(BUCKETS),
		.WAYS   (WAYS)
	) u_engine (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (hash_valid),
		.in_ready (hash_ready),
		.in_mac   (hash_mac),
		.in_bucket(hash_bucket),
		.out_valid(m_tvalid),
		.out_ready(m_tready),
		.out_res  (res)
	);

	assign m_tdata = {(OUT_TDATA_W - RES_W)'(0), res};

endmodule

`default_nettype wire

[tb/sv/testbench.sv]
`timescale 1ns / 100ps
// Self-checking testbench for mac_learning_hash_table: a directed table of
// addresses, then random traffic partly aimed at crowded buckets, checked word by word.
// Depends on mlht_pkg and the RTL of the block.

module testbench;
	import mlht_pkg::*;

	localparam int NB         = BUCKETS_DEF;
	localparam int NW         = WAYS_DEF;
	localparam int POOL_N     = 30000;
	localparam int N_DIRECTED = 18;
	localparam int N_RANDOM   = 1632;
	localparam int N_TOTAL    = N_DIRECTED + N_RANDOM;
	localparam int CALM_N     = 150;
	localparam int HOLD_AT    = 400;
	localparam int LONG_HOLD  = 300;
	localparam int PAUSE_AT   = 900;
	localparam int DRAIN      = 40;
	localparam int LIMIT      = 400000;

	typedef enum bit {ROW_FIXED, ROW_CROWD} row_kind_t;

	// For crowd rows, value is the index of the address within the chosen bucket.
	typedef struct {
		row_kind_t               kind;
		logic [MAC_W-1:0]        value;
		bit                      typed;
		logic [BUCKET_OUT_W-1:0] bucket;
		logic [WAY_OUT_W-1:0]    way;
		status_t                 status;
	} dir_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [MAC_W-1:0] s_tdata = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_tdata;

	// Expected lookup results, oldest first.
	result_t pending_lookups[$];
	int mismatches = 0;
	int words_in = 0;
	int cycles = 0;

	// Model of the table contents.
	logic [MAC_W-1:0] key_store [NB*NW];
	int fill_count [NB];

	// Random addresses sorted into buckets, so that buckets can be filled on purpose.
	logic [MAC_W-1:0] pool_mac [POOL_N];
	int pool_link [POOL_N];
	int bucket_head [NB];
	int bucket_cnt [NB];
	int crowd_q[$];

	// What the word on s_tdata is expected to produce when it was typed in the table.
	bit offer_typed = 1'b0;
	result_t offer_res = '0;

	logic [MAC_W-1:0] sent_macs[$];

	// Way numbers in the table assume four ways per bucket.
	dir_row_t directed_rows [N_DIRECTED] = '{
		'{ROW_FIXED, 48'h0, 1'b1, 14'd0, 2'd0, ST_LEARNED},
		'{ROW_FIXED, 48'h0, 1'b1, 14'd0, 2'd0, ST_PRESENT},
		'{ROW_CROWD, 48'd0, 1'b1, 14'd0, 2'd0, ST_LEARNED},
		'{ROW_CROWD, 48'd1, 1'b1, 14'd0, 2'd1, ST_LEARNED},
		'{ROW_CROWD, 48'd2, 1'b1, 14'd0, 2'd2, ST_LEARNED},
		'{ROW_CROWD, 48'd3, 1'b1, 14'd0, 2'd3, ST_LEARNED},
		'{ROW_CROWD, 48'd4, 1'b1, 14'd0, 2'd0, ST_DROPPED},
		'{ROW_CROWD, 48'd1, 1'b1, 14'd0, 2'd1, ST_PRESENT},
		'{ROW_CROWD, 48'd3, 1'b1, 14'd0, 2'd3, ST_PRESENT},
		'{ROW_CROWD, 48'd4, 1'b1, 14'd0, 2'd0, ST_DROPPED},
		'{ROW_CROWD, 48'd0, 1'b1, 14'd0, 2'd0, ST_PRESENT},
		'{ROW_FIXED, 48'hFFFF_FFFF_FFFF, 1'b0, 14'd0, 2'd0, ST_PRESENT},
		'{ROW_FIXED, 48'hFFFF_FFFF_FFFF, 1'b0, 14'd0, 2'd0, ST_PRESENT},
		'{ROW_FIXED, 48'h8000_0000_0000, 1'b0, 14'd0, 2'd0, ST_PRESENT},
		'{ROW_FIXED, 48'h0000_0000_0001, 1'b0, 14'd0, 2'd0, ST_PRESENT},
		'{ROW_FIXED, 48'hAAAA_AAAA_AAAA, 1'b0, 14'd0, 2'd0, ST_PRESENT},
		'{ROW_FIXED, 48'h5555_5555_5555, 1'b0, 14'd0, 2'd0, ST_PRESENT},
		'{ROW_FIXED, 48'h0102_0304_0506, 1'b0, 14'd0, 2'd0, ST_PRESENT}
	};

	mac_learning_hash_table #(
		.BUCKETS(NB),
		.WAYS   (NW)
	) DUT (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// One-at-a-time hash over the six address bytes, most significant first.
	function automatic logic [31:0] oat_hash(input logic [MAC_W-1:0] mac);
		logic [31:0] h;
		h = 32'd0;
		for (int b = 5; b >= 0; b--) begin
			h = h + 32'(mac[8*b +: 8]);
			h = h + (h << 10);
			h = h ^ (h >> 6);
		end
		h = h + (h << 3);
		h = h ^ (h >> 11);
		h = h + (h << 15);
		return h;
	endfunction

	function automatic int bucket_of(input logic [MAC_W-1:0] mac);
		return int'(oat_hash(mac) % NB);
	endfunction

	// Looks the address up in the model table and learns it if there is room.
	function automatic result_t learn_mac(input logic [MAC_W-1:0] mac);
		result_t r;
		int bkt;
		int fill;
		int hit_way;
		bkt = bucket_of(mac);
		fill = fill_count[bkt];
		hit_way = -1;
		for (int w = 0; w < fill; w++)
			if (hit_way < 0 && key_store[bkt*NW + w] == mac)
				hit_way = w;
		r.bucket = BUCKET_OUT_W'(bkt);
		if (hit_way >= 0) begin
			r.way = WAY_OUT_W'(hit_way);
			r.status = ST_PRESENT;
		end else if (fill < NW) begin
			key_store[bkt*NW + fill] = mac;
			fill_count[bkt] = fill + 1;
			r.way = WAY_OUT_W'(fill);
			r.status = ST_LEARNED;
		end else begin
			r.way = '0;
			r.status = ST_DROPPED;
		end
		return r;
	endfunction

	function automatic logic [MAC_W-1:0] rand_mac();
		logic [63:0] r;
		r = {$urandom, $urandom};
		return r[MAC_W-1:0];
	endfunction

	function automatic logic [MAC_W-1:0] pool_pick(input int bkt, input int k);
		int p;
		p = bucket_head[bkt];
		repeat (k) p = pool_link[p];
		return pool_mac[p];
	endfunction

	// Presents one word at the falling edge and returns at the falling edge after
	// it was taken.
	task automatic offer(input logic [MAC_W-1:0] mac, input bit typed, input result_t res,
			input bit calm);
		int gap;
		if (!calm && $urandom_range(0, 4) == 0) begin
			gap = $urandom_range(1, 11);
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		offer_typed = typed;
		offer_res = res;
		s_tvalid <= 1'b1;
		s_tdata <= mac;
		do @(posedge clk); while (!s_tready);
		@(negedge clk);
	endtask

	always @(posedge clk) begin : scoreboard
		result_t want;
		result_t got;
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				want = learn_mac(s_tdata);
				if (offer_typed)
					want = offer_res;
				pending_lookups = {pending_lookups, want};
				words_in++;
			end
			if (m_tvalid && m_tready) begin
				got = result_t'(m_tdata[RES_W-1:0]);
				if (pending_lookups.size() == 0) begin
					$error("result word with no lookup pending: %h", m_tdata);
					mismatches++;
				end else begin
					want = pending_lookups.pop_front();
					if (got.bucket !== want.bucket) begin
						$error("bucket_index expected %0d got %0d", want.bucket, got.bucket);
						mismatches++;
					end
					if (got.way !== want.way) begin
						$error("way_index expected %0d got %0d", want.way, got.way);
						mismatches++;
					end
					if (got.status !== want.status) begin
						$error("status expected %0d got %0d", want.status, got.status);
						mismatches++;
					end
				end
			end
		end
	end

	initial begin : rx_side
		int gap;
		bit held;
		held = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (!held && words_in >= HOLD_AT) begin
				// Long hold-off so that the block backs up and stops taking words.
				held = 1'b1;
				m_tready <= 1'b0;
				repeat (LONG_HOLD) @(negedge clk);
				m_tready <= 1'b1;
			end else if (words_in < N_TOTAL - CALM_N && $urandom_range(0, 5) == 0) begin
				gap = $urandom_range(1, 11);
				m_tready <= 1'b0;
				repeat (gap) @(negedge clk);
				m_tready <= 1'b1;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	initial begin : watchdog
		while (cycles < LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("[mac_learning_hash_table] ERROR");
		$finish;
	end

	initial begin : tx_side
		logic [MAC_W-1:0] mac;
		result_t res;
		int bkt;
		int crowd_bkt;
		int work_n;
		int pick;
		foreach (bucket_head[b])
			bucket_head[b] = -1;
		for (int p = 0; p < POOL_N; p++) begin
			pool_mac[p] = rand_mac();
			bkt = bucket_of(pool_mac[p]);
			pool_link[p] = bucket_head[bkt];
			bucket_head[bkt] = p;
			bucket_cnt[bkt]++;
		end
		// Bucket 0 is left out since the zero address lands there.
		for (int b = 1; b < NB; b++)
			if (bucket_cnt[b] > NW)
				crowd_q = {crowd_q, b};
		crowd_bkt = crowd_q[0];
		work_n = (crowd_q.size() > 33) ? 32 : crowd_q.size() - 1;

		repeat (6) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (directed_rows[r]) begin
			if (directed_rows[r].kind == ROW_CROWD) begin
				mac = pool_pick(crowd_bkt, int'(directed_rows[r].value));
				res.bucket = BUCKET_OUT_W'(crowd_bkt);
			end else begin
				mac = directed_rows[r].value;
				res.bucket = directed_rows[r].bucket;
			end
			res.way = directed_rows[r].way;
			res.status = directed_rows[r].status;
			offer(mac, directed_rows[r].typed, res, 1'b0);
			sent_macs = {sent_macs, mac};
		end

		for (int i = 0; i < N_RANDOM; i++) begin
			if (i == PAUSE_AT) begin
				s_tvalid <= 1'b0;
				do @(negedge clk); while (pending_lookups.size() != 0);
			end
			pick = $urandom_range(0, 99);
			if (pick < 40) begin
				bkt = crowd_q[1 + $urandom_range(0, work_n - 1)];
				mac = pool_pick(bkt, $urandom_range(0, bucket_cnt[bkt] - 1));
			end else if (pick < 65) begin
				mac = sent_macs[$urandom_range(0, sent_macs.size() - 1)];
			end else if (pick < 95) begin
				mac = rand_mac();
			end else begin
				case ($urandom_range(0, 3))
					0: mac = '0;
					1: mac = '1;
					2: mac = 48'd1 << $urandom_range(0, MAC_W - 1);
					default: mac = ~(48'd1 << $urandom_range(0, MAC_W - 1));
				endcase
			end
			offer(mac, 1'b0, '0, i >= N_RANDOM - CALM_N);
			sent_macs = {sent_macs, mac};
		end
		s_tvalid <= 1'b0;

		while (pending_lookups.size() != 0) @(posedge clk);
		repeat (DRAIN) @(posedge clk);
		if (mismatches == 0)
			$display("[mac_learning_hash_table] OK");
		else
			$display("[mac_learning_hash_table] ERROR");
		$finish;
	end

endmodule
